// File: rtl/core/dad_pkg.sv
// Shared types, constants and calendar helpers for the date adder.
// No dependencies; dad_year_ctr, dad_sub_unit and date_add_days_core refer to this package.
package dad_pkg;

  localparam int unsigned DAY_W      = 5;
  localparam int unsigned MONTH_W    = 4;
  localparam int unsigned YEAR_W     = 12;
  localparam int unsigned COUNT_W    = 16;
  // Running day sum: largest day of month plus the largest count.
  localparam int unsigned ACC_W      = COUNT_W + 1;
  // Year counter is one bit wider so it can step past the last legal year.
  localparam int unsigned YCTR_W     = YEAR_W + 1;
  localparam int unsigned LEN_W      = 9;
  localparam int unsigned MOD100_W   = 7;
  localparam int unsigned QUO_W      = 7;

  // year / 100 == (year * DIV100_MUL) >> DIV100_SHIFT for every year below 8192.
  localparam int unsigned DIV100_MUL   = 5243;
  localparam int unsigned DIV100_SHIFT = 19;
  localparam int unsigned DIV100_MW    = 13;
  localparam int unsigned PROD_W       = YCTR_W + DIV100_MW;

  localparam logic [MOD100_W-1:0] LAST_IN_CENTURY = MOD100_W'(99);
  localparam logic [MONTH_W-1:0]  MONTH_JAN       = MONTH_W'(1);
  localparam logic [MONTH_W-1:0]  MONTH_FEB       = MONTH_W'(2);
  localparam logic [MONTH_W-1:0]  MONTH_DEC       = MONTH_W'(12);
  localparam logic [LEN_W-1:0]    YEAR_LEN        = LEN_W'(365);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MOD,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } state_e;

  // Commands from the sequencer to the year counter.
  typedef struct packed {
    logic              load;
    logic              div;
    logic              modr;
    logic              inc;
    logic [YCTR_W-1:0] load_year;
  } yctr_cmd_t;

  // Status from the year counter.
  typedef struct packed {
    logic [YCTR_W-1:0] year;
    logic              leap_cur;
    logic              leap_next;
  } yctr_sts_t;

  function automatic logic [LEN_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [LEN_W-1:0] len;
    case (m)
      4'd2:                      len = leap ? LEN_W'(29) : LEN_W'(28);
      4'd4, 4'd6, 4'd9, 4'd11:   len = LEN_W'(30);
      default:                   len = LEN_W'(31);
    endcase
    return len;
  endfunction

endpackage

// File: rtl/core/dad_year_ctr.sv
// Year counter with running year-mod-100 and century-mod-4 for leap tests.
// Depends on dad_pkg.
module dad_year_ctr (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dad_pkg::yctr_cmd_t cmd_i,
  output dad_pkg::yctr_sts_t sts_o
);

  logic [dad_pkg::YCTR_W-1:0]   year_q, year_d;
  logic [dad_pkg::QUO_W-1:0]    quo_q, quo_d;
  logic [dad_pkg::MOD100_W-1:0] mod100_q, mod100_d;
  logic [1:0]                   cent_q, cent_d;

  logic [dad_pkg::PROD_W-1:0]   prod;
  logic [dad_pkg::YCTR_W+dad_pkg::QUO_W-1:0] hund;
  logic [dad_pkg::MOD100_W-1:0] mod_nxt;
  logic [1:0]                   cent_nxt;
  logic [1:0]                   year_lo_nxt;

  assign prod = dad_pkg::PROD_W'(year_q) *
                dad_pkg::PROD_W'(dad_pkg::DIV100_MUL);
  // quotient times 100 as shifts and adds: 64 + 32 + 4
  assign hund = ((dad_pkg::YCTR_W+dad_pkg::QUO_W)'(quo_q) << 6) +
                ((dad_pkg::YCTR_W+dad_pkg::QUO_W)'(quo_q) << 5) +
                ((dad_pkg::YCTR_W+dad_pkg::QUO_W)'(quo_q) << 2);

  assign mod_nxt     = (mod100_q == dad_pkg::LAST_IN_CENTURY) ? '0 : mod100_q + 1'b1;
  assign cent_nxt    = (mod100_q == dad_pkg::LAST_IN_CENTURY) ? cent_q + 1'b1 : cent_q;
  assign year_lo_nxt = year_q[1:0] + 1'b1;

  always_comb begin
    year_d   = year_q;
    quo_d    = quo_q;
    mod100_d = mod100_q;
    cent_d   = cent_q;
    if (cmd_i.load) begin
      year_d = cmd_i.load_year;
    end else if (cmd_i.div) begin
      quo_d = prod[dad_pkg::DIV100_SHIFT +: dad_pkg::QUO_W];
    end else if (cmd_i.modr) begin
      mod100_d = dad_pkg::MOD100_W'(year_q - hund[dad_pkg::YCTR_W-1:0]);
      cent_d   = quo_q[1:0];
    end else if (cmd_i.inc) begin
      year_d   = year_q + 1'b1;
      mod100_d = mod_nxt;
      cent_d   = cent_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q <= '0;
    end else begin
      year_q <= year_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q    <= quo_d;
    mod100_q <= mod100_d;
    cent_q   <= cent_d;
  end

  assign sts_o.year      = year_q;
  assign sts_o.leap_cur  = (year_q[1:0] == 2'd0 && mod100_q != '0) ||
                           (mod100_q == '0 && cent_q == 2'd0);
  assign sts_o.leap_next = (year_lo_nxt == 2'd0 && mod_nxt != '0) ||
                           (mod_nxt == '0 && cent_nxt == 2'd0);

endmodule

// File: rtl/core/dad_sub_unit.sv
// Shared compare and subtract unit: tests whether a day sum fits a span length.
// Depends on dad_pkg.
module dad_sub_unit (
  input  logic [dad_pkg::ACC_W-1:0] day_i,
  input  logic [dad_pkg::LEN_W-1:0] len_i,
  output logic [dad_pkg::ACC_W-1:0] diff_o,
  output logic                      fits_o
);

  logic [dad_pkg::ACC_W:0] wide;

  assign wide   = {1'b0, day_i} - (dad_pkg::ACC_W+1)'(len_i);
  // fits when day <= len, i.e. day - len - 1 borrows
  assign fits_o = wide[dad_pkg::ACC_W] || (wide == '0);
  assign diff_o = wide[dad_pkg::ACC_W-1:0];

endmodule

// File: rtl/core/date_add_days_core.sv
// Top level of the Gregorian date adder: sequencer, day register and output stage.
// Depends on dad_pkg, dad_year_ctr and dad_sub_unit.

// Adds a 16-bit day count to a start date (day, month, year) and returns the
// Gregorian date that many days later, with leap Februaries counted as 29
// days. A start date with day 0, a month outside 1..12 or a year outside
// FIRST_YEAR..LAST_YEAR is replaced by 1.1.FIRST_YEAR and flagged; a result
// past LAST_YEAR is forced to 1.1.FIRST_YEAR and flagged as well. A start day
// too large for its month simply rolls forward. One beat is worked on at a
// time: after acceptance, states ST_DIV and ST_MOD prepare the year-mod-100
// counters, then ST_YEAR skips whole years one at a time, then ST_MONTH
// steps month by month (at most eleven steps plus one final check), then
// ST_DONE moves the result into the output register once that register is
// free. Both the year and the month walk go through the single shared
// compare-and-subtract unit. The input side reopens as soon as the result is
// in the output register, so a waiting result does not hold off the next beat.
module date_add_days_core #(
  parameter int unsigned FIRST_YEAR = 1970,
  parameter int unsigned LAST_YEAR  = 2099
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // start_day [4:0], start_month [8:5], start_year [20:9], day_count [36:21]
  input  logic [39:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // result_day [4:0], result_month [8:5], result_year [20:9]
  output logic [23:0] m_axis_tdata,
  // result_defaulted [0]
  output logic        m_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready
);

  localparam logic [dad_pkg::YCTR_W-1:0] FirstYr = dad_pkg::YCTR_W'(FIRST_YEAR);
  localparam logic [dad_pkg::YCTR_W-1:0] LastYr  = dad_pkg::YCTR_W'(LAST_YEAR);

  dad_pkg::state_e state_q, state_d;

  logic [dad_pkg::ACC_W-1:0]   day_q, day_d;
  logic [dad_pkg::MONTH_W-1:0] month_q, month_d;
  logic                        flag_q, flag_d;

  logic [dad_pkg::DAY_W-1:0]   out_day_q, out_day_d;
  logic [dad_pkg::MONTH_W-1:0] out_month_q, out_month_d;
  logic [dad_pkg::YEAR_W-1:0]  out_year_q, out_year_d;
  logic                        out_flag_q, out_flag_d;
  logic                        out_valid_q, out_valid_d;

  // Unpack the input beat.
  logic [dad_pkg::DAY_W-1:0]   in_day;
  logic [dad_pkg::MONTH_W-1:0] in_month;
  logic [dad_pkg::YEAR_W-1:0]  in_year;
  logic [dad_pkg::COUNT_W-1:0] in_count;
  logic                        in_ok;
  logic                        in_beat;

  assign in_day   = s_axis_tdata[4:0];
  assign in_month = s_axis_tdata[8:5];
  assign in_year  = s_axis_tdata[20:9];
  assign in_count = s_axis_tdata[36:21];

  assign in_ok = (in_day != '0) &&
                 (in_month >= dad_pkg::MONTH_JAN) && (in_month <= dad_pkg::MONTH_DEC) &&
                 (dad_pkg::YCTR_W'(in_year) >= FirstYr) &&
                 (dad_pkg::YCTR_W'(in_year) <= LastYr);

  assign s_axis_tready = (state_q == dad_pkg::ST_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  dad_pkg::yctr_cmd_t yc_cmd;
  dad_pkg::yctr_sts_t yc_sts;

  dad_year_ctr u_year_ctr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (yc_cmd),
    .sts_o  (yc_sts)
  );

  // One shared subtractor serves both the year walk and the month walk.
  logic [dad_pkg::LEN_W-1:0] span_len;
  logic [dad_pkg::ACC_W-1:0] sub_diff;
  logic                      sub_fits;
  logic                      past_last;
  logic                      feb_crossed_leap;

  // A full year starting in Jan or Feb crosses this year's February,
  // otherwise next year's.
  assign feb_crossed_leap = (month_q <= dad_pkg::MONTH_FEB) ? yc_sts.leap_cur
                                                            : yc_sts.leap_next;
  assign past_last        = (yc_sts.year > LastYr);

  always_comb begin
    if (state_q == dad_pkg::ST_YEAR) begin
      span_len = dad_pkg::YEAR_LEN + dad_pkg::LEN_W'(feb_crossed_leap);
    end else begin
      span_len = dad_pkg::month_len(month_q, yc_sts.leap_cur);
    end
  end

  dad_sub_unit u_sub (
    .day_i  (day_q),
    .len_i  (span_len),
    .diff_o (sub_diff),
    .fits_o (sub_fits)
  );

  // Sequencer: next state, datapath updates and year counter commands.
  always_comb begin
    state_d     = state_q;
    day_d       = day_q;
    month_d     = month_q;
    flag_d      = flag_q;
    out_day_d   = out_day_q;
    out_month_d = out_month_q;
    out_year_d  = out_year_q;
    out_flag_d  = out_flag_q;
    out_valid_d = out_valid_q;

    yc_cmd           = '0;
    yc_cmd.load_year = in_ok ? dad_pkg::YCTR_W'(in_year) : FirstYr;

    // Drop the held result once the sink takes it.
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      dad_pkg::ST_IDLE: begin
        if (in_beat) begin
          // Substitute 1.1.FIRST_YEAR for a bad start date, then add the count.
          day_d       = (in_ok ? dad_pkg::ACC_W'(in_day) : dad_pkg::ACC_W'(1)) +
                        dad_pkg::ACC_W'(in_count);
          month_d     = in_ok ? in_month : dad_pkg::MONTH_JAN;
          flag_d      = !in_ok;
          yc_cmd.load = 1'b1;
          state_d     = dad_pkg::ST_DIV;
        end
      end
      dad_pkg::ST_DIV: begin
        yc_cmd.div = 1'b1;
        state_d    = dad_pkg::ST_MOD;
      end
      dad_pkg::ST_MOD: begin
        yc_cmd.modr = 1'b1;
        state_d     = dad_pkg::ST_YEAR;
      end
      dad_pkg::ST_YEAR: begin
        // Skip whole years while the sum exceeds the next twelve months.
        if (!past_last && !sub_fits) begin
          day_d      = sub_diff;
          yc_cmd.inc = 1'b1;
        end else begin
          state_d = dad_pkg::ST_MONTH;
        end
      end
      dad_pkg::ST_MONTH: begin
        if (past_last || sub_fits) begin
          state_d = dad_pkg::ST_DONE;
        end else begin
          day_d = sub_diff;
          if (month_q == dad_pkg::MONTH_DEC) begin
            month_d    = dad_pkg::MONTH_JAN;
            yc_cmd.inc = 1'b1;
          end else begin
            month_d = month_q + 1'b1;
          end
        end
      end
      dad_pkg::ST_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_q || m_axis_tready) begin
          if (past_last) begin
            out_day_d   = dad_pkg::DAY_W'(1);
            out_month_d = dad_pkg::MONTH_JAN;
            out_year_d  = dad_pkg::YEAR_W'(FIRST_YEAR);
            out_flag_d  = 1'b1;
          end else begin
            out_day_d   = day_q[dad_pkg::DAY_W-1:0];
            out_month_d = month_q;
            out_year_d  = yc_sts.year[dad_pkg::YEAR_W-1:0];
            out_flag_d  = flag_q;
          end
          out_valid_d = 1'b1;
          state_d     = dad_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dad_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dad_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    day_q       <= day_d;
    month_q     <= month_d;
    flag_q      <= flag_d;
    out_day_q   <= out_day_d;
    out_month_q <= out_month_d;
    out_year_q  <= out_year_d;
    out_flag_q  <= out_flag_d;
  end

  assign m_axis_tdata  = {3'b000, out_year_q, out_month_q, out_day_q};
  assign m_axis_tuser  = out_flag_q;
  assign m_axis_tvalid = out_valid_q;

endmodule

// File: rtl/core/dad_checker.sv
// Port-level checks for the date adder, attached to the top level by bind.
// Depends on date_add_days_core's port list only.
module dad_checker #(
  parameter int unsigned FIRST_YEAR = 1970,
  parameter int unsigned LAST_YEAR  = 2099
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready
);

  logic in_beat;
  assign in_beat = s_axis_tvalid && s_axis_tready;

  // One beat at a time: the input closes right after acceptance.
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !s_axis_tready)
    else $error("input still ready after acceptance");

  // Month of a result always names a real month.
  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[8:5] != 4'd0) && (m_axis_tdata[8:5] <= 4'd12))
    else $error("result month out of range");

  // Year and day of a result stay inside the calendar window.
  a_year_day_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[20:9] >= 12'(FIRST_YEAR)) &&
                      (m_axis_tdata[20:9] <= 12'(LAST_YEAR)) &&
                      (m_axis_tdata[4:0] != 5'd0))
    else $error("result date out of range");

  // A result cannot appear right after an accepted beat.
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind date_add_days_core dad_checker #(
  .FIRST_YEAR (FIRST_YEAR),
  .LAST_YEAR  (LAST_YEAR)
) u_dad_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

// File: bench/tb_date_add_days_core.sv
// Self-checking testbench for date_add_days_core: drives start dates and day counts
// on the input stream and checks every result beat against a calendar predictor.
// Depends on dad_pkg and the date_add_days_core RTL.
module tb_date_add_days_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned EPOCH_YEAR = 1970;
  localparam int unsigned FINAL_YEAR = 2099;
  // Days from 1.1.EPOCH_YEAR to 1.1.(FINAL_YEAR + 1).
  localparam int unsigned SPAN_DAYS  = 47482;

  typedef struct packed {
    logic [dad_pkg::COUNT_W-1:0] count;
    logic [dad_pkg::YEAR_W-1:0]  year;
    logic [dad_pkg::MONTH_W-1:0] month;
    logic [dad_pkg::DAY_W-1:0]   day;
  } date_req_t;

  typedef struct packed {
    logic                        defaulted;
    logic [dad_pkg::YEAR_W-1:0]  year;
    logic [dad_pkg::MONTH_W-1:0] month;
    logic [dad_pkg::DAY_W-1:0]   day;
  } date_res_t;

  typedef enum int unsigned {
    RX_STEADY,
    RX_COIN,
    RX_SPARSE,
    RX_STROBE
  } rx_mode_e;

  logic        clk_i;
  logic        rst_ni;
  logic [39:0] s_axis_tdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;

  date_res_t   pending_dates[$];
  int unsigned mismatch_count;
  int unsigned rx_hold_req;
  int unsigned burst_left;

  date_add_days_core #(
    .FIRST_YEAR(EPOCH_YEAR),
    .LAST_YEAR (FINAL_YEAR)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------
  function automatic bit is_leap(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Long months alternate, with the odd/even sense flipping from August on.
  function automatic int unsigned month_days(int unsigned m, int unsigned y);
    if (m == dad_pkg::MONTH_FEB) begin
      return is_leap(y) ? 29 : 28;
    end
    return 30 + ((m + (m >> 3)) & 1);
  endfunction

  function automatic date_res_t add_days_to_date(date_req_t r);
    int unsigned d;
    int unsigned m;
    int unsigned y;
    bit          flag;
    date_res_t   res;
    d    = r.day;
    m    = r.month;
    y    = r.year;
    flag = 1'b0;
    // Replace a bad start date by the epoch and keep adding the count.
    if (d < 1 || m < dad_pkg::MONTH_JAN || m > dad_pkg::MONTH_DEC ||
        y < EPOCH_YEAR || y > FINAL_YEAR) begin
      d    = 1;
      m    = dad_pkg::MONTH_JAN;
      y    = EPOCH_YEAR;
      flag = 1'b1;
    end
    d += r.count;
    while (y <= FINAL_YEAR && d > month_days(m, y)) begin
      d -= month_days(m, y);
      if (m == dad_pkg::MONTH_DEC) begin
        m = dad_pkg::MONTH_JAN;
        y++;
      end else begin
        m++;
      end
    end
    // Past the last year: fall back to the epoch.
    if (y > FINAL_YEAR) begin
      d    = 1;
      m    = dad_pkg::MONTH_JAN;
      y    = EPOCH_YEAR;
      flag = 1'b1;
    end
    res.day       = dad_pkg::DAY_W'(d);
    res.month     = dad_pkg::MONTH_W'(m);
    res.year      = dad_pkg::YEAR_W'(y);
    res.defaulted = flag;
    return res;
  endfunction

  function automatic date_req_t make_req(int unsigned d, int unsigned m, int unsigned y,
                                         int unsigned c);
    date_req_t r;
    r.day   = dad_pkg::DAY_W'(d);
    r.month = dad_pkg::MONTH_W'(m);
    r.year  = dad_pkg::YEAR_W'(y);
    r.count = dad_pkg::COUNT_W'(c);
    return r;
  endfunction

  // Mostly well-formed dates, with a share of out-of-range day, month and year fields.
  function automatic date_req_t rand_req();
    int unsigned d;
    int unsigned m;
    int unsigned y;
    int unsigned c;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 16)       y = $urandom_range(EPOCH_YEAR, FINAL_YEAR);
    else if (pick < 18)  y = $urandom_range(0, (1 << dad_pkg::YEAR_W) - 1);
    else                 y = $urandom_range(FINAL_YEAR - 1, FINAL_YEAR + 1);
    pick = $urandom_range(0, 19);
    if (pick < 17)       m = $urandom_range(1, 12);
    else                 m = $urandom_range(0, (1 << dad_pkg::MONTH_W) - 1);
    pick = $urandom_range(0, 19);
    if (pick < 13)       d = $urandom_range(1, 31);
    else if (pick < 17)  d = $urandom_range(27, 31);
    else                 d = $urandom_range(0, (1 << dad_pkg::DAY_W) - 1);
    pick = $urandom_range(0, 9);
    if (pick < 4)        c = $urandom_range(0, 400);
    else if (pick < 7)   c = $urandom_range(0, 20000);
    else if (pick < 9)   c = $urandom_range(0, (1 << dad_pkg::COUNT_W) - 1);
    else                 c = $urandom_range(SPAN_DAYS - 800, SPAN_DAYS + 50);
    return make_req(d, m, y, c);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: call at a falling edge; returns after the beat is taken, with tvalid
  // dropped, while the core is still busy with that beat.
  // ---------------------------------------------------------------------------
  task automatic send_date(input date_req_t r);
    s_axis_tdata  <= {3'b000, r};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_dates.push_back(add_days_to_date(r));
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic idle_sender(input int unsigned cycles);
    if (cycles != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (cycles) @(negedge clk_i);
    end
  endtask

  // Hold the input side off until every result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_dates.size() != 0);
  endtask

  // Send in bursts of random length, with short gaps mostly and long ones
  // now and then so idles land in every phase of the year and month walk.
  task automatic send_bursty(input date_req_t r);
    if (burst_left == 0) begin
      if ($urandom_range(0, 9) == 0) idle_sender($urandom_range(20, 220));
      else                           idle_sender($urandom_range(1, 6));
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
    end
    burst_left--;
    send_date(r);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_bad_start();
    send_date(make_req(0, 6, 2000, 10));
    send_date(make_req(15, 0, 2000, 10));
    send_date(make_req(15, 13, 2000, 0));
    send_date(make_req(31, 15, 4095, 65535));
    send_date(make_req(1, 1, 1969, 31));
    send_date(make_req(1, 1, 2100, 0));
    send_date(make_req(0, 0, 0, 0));
    send_date(make_req(31, 12, 4095, 365));
  endtask

  task automatic test_month_ends();
    send_date(make_req(31, 4, 2001, 0));
    send_date(make_req(31, 2, 2001, 0));
    send_date(make_req(31, 2, 2000, 0));
    send_date(make_req(28, 2, 2000, 1));
    send_date(make_req(28, 2, 2096, 1));
    send_date(make_req(28, 2, 2097, 1));
    send_date(make_req(31, 1, 1999, 29));
    send_date(make_req(1, 1, 1970, 0));
  endtask

  task automatic test_year_limit();
    send_date(make_req(31, 12, 2099, 0));
    send_date(make_req(30, 12, 2099, 1));
    send_date(make_req(31, 12, 2099, 1));
    send_date(make_req(1, 1, 1970, SPAN_DAYS - 1));
    send_date(make_req(1, 1, 1970, SPAN_DAYS));
    send_date(make_req(1, 1, 1970, 65535));
    send_date(make_req(31, 12, 2099, 65535));
  endtask

  // Stall the output for a long stretch while beats keep coming, so the core
  // fills and drops tready on its input.
  task automatic test_output_stall();
    int unsigned i;
    @(posedge clk_i);
    rx_hold_req = 700;
    @(negedge clk_i);
    for (i = 0; i < 8; i++) begin
      send_date(make_req($urandom_range(1, 28), $urandom_range(1, 12),
                         $urandom_range(EPOCH_YEAR, FINAL_YEAR), $urandom_range(0, 40)));
    end
    drain_results();
  endtask

  task automatic test_random_traffic(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) begin
      send_bursty(rand_req());
    end
  endtask

  // Let the pipe run dry in the middle of traffic, then resume.
  task automatic test_drain_pause();
    test_random_traffic(30);
    drain_results();
    test_random_traffic(30);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: own stall pattern, plus a counted long hold on request
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    int unsigned mode_left;
    int unsigned strobe_cnt;
    rx_mode_e    mode;
    hold_left     = 0;
    mode_left     = 0;
    strobe_cnt    = 0;
    mode          = RX_STEADY;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req != 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(64, 600);
        end
        mode_left--;
        strobe_cnt++;
        case (mode)
          RX_STEADY: m_axis_tready <= 1'b1;
          RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: m_axis_tready <= ($urandom_range(0, 7) == 0);
          default:   m_axis_tready <= (strobe_cnt % 4 == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  initial begin
    date_res_t want;
    date_res_t got;
    mismatch_count = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.day       = m_axis_tdata[4:0];
        got.month     = m_axis_tdata[8:5];
        got.year      = m_axis_tdata[20:9];
        got.defaulted = m_axis_tuser;
        if (pending_dates.size() == 0) begin
          $error("unexpected result beat: day %0d month %0d year %0d defaulted %0d",
                 got.day, got.month, got.year, got.defaulted);
          mismatch_count++;
        end else begin
          want = pending_dates.pop_front();
          if (got.day != want.day) begin
            $error("result_day: expected %0d, got %0d", want.day, got.day);
            mismatch_count++;
          end
          if (got.month != want.month) begin
            $error("result_month: expected %0d, got %0d", want.month, got.month);
            mismatch_count++;
          end
          if (got.year != want.year) begin
            $error("result_year: expected %0d, got %0d", want.year, got.year);
            mismatch_count++;
          end
          if (got.defaulted != want.defaulted) begin
            $error("result_defaulted: expected %0d, got %0d", want.defaulted, got.defaulted);
            mismatch_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    rx_hold_req   = 0;
    burst_left    = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_bad_start();
    test_month_ends();
    test_year_limit();
    test_output_stall();
    test_random_traffic(800);
    test_drain_pause();
    test_random_traffic(720);

    // Wait out the last results, then watch for stray beats a while longer.
    drain_results();
    repeat (250) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_date_add_days_core: done, clean");
    end else begin
      $display("tb_date_add_days_core: done, errors");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb_date_add_days_core: done, errors");
    $finish;
  end

endmodule
